### rtl/core/quadratic_tracking_cost_accumulator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_TRACKING_COST_ACCUMULATOR_UNIT_ASSERT_SVH
`define QUADRATIC_TRACKING_COST_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QTCA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define QTCA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define QTCA_ASSERT(lbl, cond, msg)
`define QTCA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/qtca_pkg.sv
// ----------------------------------------------------------------------------
// qtca_pkg
// Constants, codes, types and helpers of the quadratic cost accumulator.
// ----------------------------------------------------------------------------
package qtca_pkg;

	localparam int MAX_STATES = 12;
	localparam int MAX_INPUTS = 4;
	localparam int FRAC_BITS  = 16;

	localparam int NUM_MATS  = 4;
	localparam int MAT_SIZE  = MAX_STATES * MAX_STATES;
	localparam int RAM_DEPTH = NUM_MATS * MAT_SIZE;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	localparam int WORD_W = 32;
	localparam int DEV_W  = WORD_W + 1;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int RND_W  = PROD_W - FRAC_BITS;
	localparam int ACC_W  = 64;

	localparam int MAX_DIM   = (MAX_STATES > MAX_INPUTS) ? MAX_STATES : MAX_INPUTS;
	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W     = $clog2(MAX_DIM + 1);
	localparam int ST_IDX_W  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int IN_IDX_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

	// row sum width, and its split into two multiplier passes
	localparam int T_W   = RND_W + $clog2(MAX_DIM) + 1;
	localparam int TL    = (T_W + 1) / 2;
	localparam int SUM_A = MUL_W + T_W + 1;
	localparam int SUM_W = (SUM_A > ACC_W + FRAC_BITS) ? SUM_A : ACC_W + FRAC_BITS;

	localparam logic [ACC_W-1:0]        MAG_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STATES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_INPUTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_SHIFTED   = 2'd2;
	localparam logic [3:0] RST_ACTIVE_STATES = 4'd12;
	localparam logic [2:0] RST_ACTIVE_INPUTS = 3'd4;

	localparam logic [1:0] MAT_Q  = 2'd0;
	localparam logic [1:0] MAT_R  = 2'd1;
	localparam logic [1:0] MAT_P  = 2'd2;
	localparam logic [1:0] MAT_PS = 2'd3;

	typedef enum logic [2:0] {
		OP_WRITE    = 3'd0,
		OP_CLEAR    = 3'd1,
		OP_STATE    = 3'd2,
		OP_INPUT    = 3'd3,
		OP_STAGE    = 3'd4,
		OP_TERMINAL = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		MS_WEIGHT,
		MS_THI,
		MS_TLO
	} mul_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAC_ADDR,
		S_MAC_MUL,
		S_T_ACC,
		S_T_HI,
		S_T_LO,
		S_T_SUM,
		S_T_ADD,
		S_FOLD,
		S_HALF,
		S_OBJ
	} state_t;

	typedef struct packed {
		logic             st_we;
		logic             in_we;
		logic [IDX_W-1:0] wr_idx;
		logic             dev_inp;
		logic [IDX_W-1:0] dev_idx;
		logic             mul_en;
		mul_src_t         mul_src;
		logic             t_clr;
		logic             t_acc;
		logic             term_sum;
		logic             term_add;
		logic             fold;
		logic             half;
		logic             obj_upd;
		logic             clr;
		logic             cmd_init;
	} ctl_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sum;
		logic                    ovf;
	} sat_res_t;

	function automatic sat_res_t sat_add(logic signed [ACC_W-1:0] a,
			logic signed [ACC_W-1:0] b);
		sat_res_t res;
		logic signed [ACC_W-1:0] s;
		s = a + b;
		res.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
		res.sum = res.ovf ? (b[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] ram_addr(logic [1:0] sel,
			logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		return ADDR_W'(int'(sel) * MAT_SIZE + int'(r) * MAX_STATES + int'(c));
	endfunction

endpackage

### rtl/core/qtca_weight_ram.sv
// ----------------------------------------------------------------------------
// qtca_weight_ram
// Weight store for the four matrices: one write port, one registered read port.
// ----------------------------------------------------------------------------
module qtca_weight_ram import qtca_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [RAM_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/qtca_datapath.sv
// ----------------------------------------------------------------------------
// qtca_datapath
// Deviation registers, shared 33x33 multiplier, rounding and accumulators.
// ----------------------------------------------------------------------------
`include "quadratic_tracking_cost_accumulator_unit_assert.svh"

module qtca_datapath import qtca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	input  logic signed [WORD_W-1:0] value,
	input  logic signed [WORD_W-1:0] reference,
	input  logic [WORD_W-1:0]        wdata,
	output logic signed [ACC_W-1:0]  objective,
	output logic                     overflow
);

	logic signed [DEV_W-1:0] st_dev_q [MAX_STATES];
	logic signed [DEV_W-1:0] in_dev_q [MAX_INPUTS];
	logic signed [DEV_W-1:0] new_dev;
	logic signed [DEV_W-1:0] dev_sel;

	logic              w_neg;
	logic [WORD_W-1:0] w_mag;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] hi_q;
	logic              neg_q;

	logic signed [T_W-1:0] t_q;
	logic [T_W-1:0]        t_mag;
	logic [PROD_W-1:0]     rnd_sum;
	logic signed [T_W-1:0] t_step;

	logic [SUM_W-1:0]        sum_next;
	logic [SUM_W-1:0]        sum_q;
	logic                    term_sat;
	logic [ACC_W-1:0]        term_mag;
	logic signed [ACC_W-1:0] term;

	logic signed [ACC_W-1:0] total_q;
	logic signed [ACC_W-1:0] fa_q;
	logic signed [ACC_W-1:0] half_q;
	logic signed [ACC_W-1:0] obj_q;
	logic                    ovf_q;
	logic [ACC_W-1:0]        fa_mag;
	logic [ACC_W:0]          half_mag;
	logic signed [ACC_W-1:0] half_v;

	sat_res_t term_res;
	sat_res_t fold_res;
	sat_res_t obj_res;

	assign new_dev = DEV_W'(value) - DEV_W'(reference);
	assign dev_sel = ctl.dev_inp ? in_dev_q[ctl.dev_idx[IN_IDX_W-1:0]]
	                             : st_dev_q[ctl.dev_idx[ST_IDX_W-1:0]];

	assign w_neg = wdata[WORD_W-1];
	assign w_mag = w_neg ? (~wdata + 1'b1) : wdata;
	assign mul_a = dev_sel[DEV_W-1] ? MUL_W'(-dev_sel) : MUL_W'(dev_sel);
	assign t_mag = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);

	always_comb begin
		unique case (ctl.mul_src)
			MS_WEIGHT: mul_b = MUL_W'(w_mag);
			MS_THI:    mul_b = MUL_W'(t_mag[T_W-1:TL]);
			MS_TLO:    mul_b = MUL_W'(t_mag[TL-1:0]);
			default:   mul_b = '0;
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// round half away from zero on the magnitude
	assign rnd_sum = prod_q + (PROD_W'(1) << (FRAC_BITS - 1));
	assign t_step  = signed'({{(T_W - RND_W){1'b0}}, rnd_sum[PROD_W-1:FRAC_BITS]});

	assign sum_next = (SUM_W'(hi_q) << TL) + SUM_W'(prod_q)
	                + (SUM_W'(1) << (FRAC_BITS - 1));
	assign term_sat = |sum_q[SUM_W-1:ACC_W-1+FRAC_BITS];
	assign term_mag = term_sat ? MAG_CAP : ACC_W'(sum_q[ACC_W-2+FRAC_BITS:FRAC_BITS]);
	assign term     = neg_q ? -signed'(term_mag) : signed'(term_mag);

	assign term_res = sat_add(total_q, term);
	assign fold_res = sat_add(fa_q, total_q);
	assign obj_res  = sat_add(obj_q, half_q);

	assign fa_mag   = fa_q[ACC_W-1] ? ACC_W'(-fa_q) : ACC_W'(fa_q);
	assign half_mag = ({1'b0, fa_mag} + 1'b1) >> 1;
	assign half_v   = fa_q[ACC_W-1] ? -signed'(half_mag[ACC_W-1:0])
	                                : signed'(half_mag[ACC_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_STATES; k++) begin
				st_dev_q[k] <= '0;
			end
			for (int k = 0; k < MAX_INPUTS; k++) begin
				in_dev_q[k] <= '0;
			end
			obj_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (ctl.st_we) begin
				st_dev_q[ctl.wr_idx[ST_IDX_W-1:0]] <= new_dev;
			end
			if (ctl.in_we) begin
				in_dev_q[ctl.wr_idx[IN_IDX_W-1:0]] <= new_dev;
			end
			if (ctl.clr) begin
				obj_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (ctl.obj_upd) begin
					obj_q <= obj_res.sum;
				end
				ovf_q <= ovf_q | (ctl.term_add & (term_sat | term_res.ovf))
				       | (ctl.fold & fold_res.ovf) | (ctl.obj_upd & obj_res.ovf);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= mul_p;
			unique case (ctl.mul_src)
				MS_WEIGHT: neg_q <= w_neg ^ dev_sel[DEV_W-1];
				MS_THI:    neg_q <= dev_sel[DEV_W-1] ^ t_q[T_W-1];
				MS_TLO:    hi_q <= prod_q;
				default:   neg_q <= neg_q;
			endcase
		end
		if (ctl.t_clr) begin
			t_q <= '0;
		end else if (ctl.t_acc) begin
			t_q <= neg_q ? (t_q - t_step) : (t_q + t_step);
		end
		if (ctl.term_sum) begin
			sum_q <= sum_next;
		end
		if (ctl.cmd_init) begin
			total_q <= '0;
			fa_q    <= '0;
		end else if (ctl.term_add) begin
			total_q <= term_res.sum;
		end else if (ctl.fold) begin
			fa_q    <= fold_res.sum;
			total_q <= '0;
		end
		if (ctl.half) begin
			half_q <= half_v;
		end
	end

	assign objective = obj_q;
	assign overflow  = ovf_q;

	`QTCA_ASSERT_IMP(a_ovf_drop, $fell(ovf_q), $past(ctl.clr), "overflow dropped without clear")
	`QTCA_ASSERT_IMP(a_obj_write, !$stable(obj_q), $past(ctl.clr) || $past(ctl.obj_upd), "objective changed outside update")

endmodule

### rtl/core/qtca_seq.sv
// ----------------------------------------------------------------------------
// qtca_seq
// Command decode and row/column sequencer for the quadratic forms.
// ----------------------------------------------------------------------------
`include "quadratic_tracking_cost_accumulator_unit_assert.svh"

module qtca_seq import qtca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        op,
	input  logic [1:0]        matrix_sel,
	input  logic [3:0]        row,
	input  logic [3:0]        col,
	input  logic [3:0]        element_index,
	input  logic [3:0]        active_states,
	input  logic [2:0]        active_inputs,
	input  logic              use_shifted_terminal,
	output logic              busy,
	output logic              done,
	output ctl_t              ctl,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [ADDR_W-1:0] ram_raddr
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [1:0]       mat_q, mat_d;
	logic             inp_q, inp_d;
	logic             stage_q, stage_d;
	logic             done_q, done_d;
	logic [CNT_W-1:0] ns;
	logic [CNT_W-1:0] ni;

	assign ns = (int'(active_states) > MAX_STATES) ? CNT_W'(MAX_STATES)
	                                               : CNT_W'(active_states);
	assign ni = (int'(active_inputs) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS)
	                                               : CNT_W'(active_inputs);

	assign ram_waddr = ram_addr(matrix_sel, row[IDX_W-1:0], col[IDX_W-1:0]);
	assign ram_raddr = ram_addr(mat_q, i_q[IDX_W-1:0], j_q[IDX_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			mat_q   <= MAT_Q;
			inp_q   <= 1'b0;
			stage_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			n_q     <= n_d;
			mat_q   <= mat_d;
			inp_q   <= inp_d;
			stage_q <= stage_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		n_d     = n_q;
		mat_d   = mat_q;
		inp_d   = inp_q;
		stage_d = stage_q;
		done_d  = 1'b0;
		ram_we  = 1'b0;
		ctl         = '0;
		ctl.wr_idx  = element_index[IDX_W-1:0];
		ctl.dev_inp = inp_q;
		ctl.dev_idx = j_q[IDX_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_WRITE: begin
							ram_we = (int'(row) < MAX_STATES) && (int'(col) < MAX_STATES);
						end
						OP_CLEAR: begin
							ctl.clr = 1'b1;
							done_d  = 1'b1;
						end
						OP_STATE: begin
							ctl.st_we = int'(element_index) < MAX_STATES;
						end
						OP_INPUT: begin
							ctl.in_we = int'(element_index) < MAX_INPUTS;
						end
						OP_STAGE, OP_TERMINAL: begin
							ctl.cmd_init = 1'b1;
							if (op == OP_STAGE) begin
								mat_d = MAT_Q;
							end else begin
								mat_d = use_shifted_terminal ? MAT_PS : MAT_P;
							end
							stage_d = (op == OP_STAGE);
							inp_d   = 1'b0;
							n_d     = ns;
							i_d     = '0;
							j_d     = '0;
							state_d = (ns == '0) ? S_FOLD : S_MAC_ADDR;
						end
						default: begin
							// unused codes: drop the word
						end
					endcase
				end
			end
			S_MAC_ADDR: begin
				// weight read issues here; fold in the previous column product
				if (j_q == '0) begin
					ctl.t_clr = 1'b1;
				end else begin
					ctl.t_acc = 1'b1;
				end
				state_d = S_MAC_MUL;
			end
			S_MAC_MUL: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_src = MS_WEIGHT;
				if (j_q + 1'b1 == n_q) begin
					j_d     = '0;
					state_d = S_T_ACC;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = S_MAC_ADDR;
				end
			end
			S_T_ACC: begin
				ctl.t_acc = 1'b1;
				state_d   = S_T_HI;
			end
			S_T_HI: begin
				ctl.dev_idx = i_q[IDX_W-1:0];
				ctl.mul_en  = 1'b1;
				ctl.mul_src = MS_THI;
				state_d     = S_T_LO;
			end
			S_T_LO: begin
				ctl.dev_idx = i_q[IDX_W-1:0];
				ctl.mul_en  = 1'b1;
				ctl.mul_src = MS_TLO;
				state_d     = S_T_SUM;
			end
			S_T_SUM: begin
				ctl.term_sum = 1'b1;
				state_d      = S_T_ADD;
			end
			S_T_ADD: begin
				ctl.term_add = 1'b1;
				if (i_q + 1'b1 == n_q) begin
					i_d     = '0;
					state_d = S_FOLD;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_MAC_ADDR;
				end
			end
			S_FOLD: begin
				ctl.fold = 1'b1;
				if (stage_q) begin
					// advance to the input form of a stage command
					stage_d = 1'b0;
					mat_d   = MAT_R;
					inp_d   = 1'b1;
					n_d     = ni;
					i_d     = '0;
					j_d     = '0;
					state_d = (ni == '0) ? S_FOLD : S_MAC_ADDR;
				end else begin
					state_d = S_HALF;
				end
			end
			S_HALF: begin
				ctl.half = 1'b1;
				state_d  = S_OBJ;
			end
			S_OBJ: begin
				ctl.obj_upd = 1'b1;
				done_d      = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`QTCA_ASSERT(a_done_idle, !done_q || state_q == S_IDLE, "result strobe while busy")
	`QTCA_ASSERT_IMP(a_busy_start, $rose(busy), $past(start), "busy rose without a start")
	`QTCA_ASSERT_IMP(a_mac_range, state_q == S_MAC_ADDR || state_q == S_MAC_MUL, j_q < n_q && i_q < n_q, "form index out of range")

endmodule

### rtl/core/quadratic_tracking_cost_accumulator_unit.sv
// ----------------------------------------------------------------------------
// quadratic_tracking_cost_accumulator_unit
// Q16.16 tracking cost evaluator: 0.5(d'Qd + e'Re) and 0.5 d'Pd into a
// saturating 64-bit objective.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Weight writes,
// state and input element loads leave busy low. A clear gives its result on
// the next cycle. A stage cost command and a terminal cost command keep busy
// high while they run, after which done pulses for one cycle with objective
// and overflow valid; the receiver
// cannot stall, so capture the result on that cycle. Each weight entry takes
// a weight memory read and then a multiply on the single 33x33 multiplier,
// and each row adds a row term, which is multiplied in two halves. The
// weight memory has no reset; read only written entries.
// ----------------------------------------------------------------------------
module quadratic_tracking_cost_accumulator_unit import qtca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	output logic                     done,
	input  logic [2:0]               op,
	input  logic [1:0]               matrix_sel,
	input  logic [3:0]               row,
	input  logic [3:0]               col,
	input  logic signed [WORD_W-1:0] weight,
	input  logic [3:0]               element_index,
	input  logic signed [WORD_W-1:0] value,
	input  logic signed [WORD_W-1:0] reference,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output logic signed [ACC_W-1:0]  objective,
	output logic                     overflow
);

	logic [3:0]        active_states_q;
	logic [2:0]        active_inputs_q;
	logic              use_shifted_q;
	ctl_t              ctl;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_states_q <= RST_ACTIVE_STATES;
			active_inputs_q <= RST_ACTIVE_INPUTS;
			use_shifted_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_STATES: active_states_q <= cfg_data[3:0];
				CFG_ACTIVE_INPUTS: active_inputs_q <= cfg_data[2:0];
				CFG_USE_SHIFTED:   use_shifted_q   <= cfg_data[0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	qtca_seq u_seq (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.op                   (op),
		.matrix_sel           (matrix_sel),
		.row                  (row),
		.col                  (col),
		.element_index        (element_index),
		.active_states        (active_states_q),
		.active_inputs        (active_inputs_q),
		.use_shifted_terminal (use_shifted_q),
		.busy                 (busy),
		.done                 (done),
		.ctl                  (ctl),
		.ram_we               (ram_we),
		.ram_waddr            (ram_waddr),
		.ram_raddr            (ram_raddr)
	);

	qtca_weight_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (weight),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	qtca_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.value     (value),
		.reference (reference),
		.wdata     (ram_rdata),
		.objective (objective),
		.overflow  (overflow)
	);

endmodule
